// File: sv/rbnh_pkg.sv
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared widths, codes, types and helpers for the ray/box nearest-hit block.
// ----------------------------------------------------------------------------
package rbnh_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W     = 6;
  localparam int COORD_W    = 32;
  localparam int EXT_W      = 31;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int OFS_W      = COORD_W + 2;
  localparam int DVS_W      = 32;
  localparam int QBITS      = 31;
  localparam int T_W        = QBITS + 2;
  localparam int DIV_STAGES = QBITS;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(32768);

  // Clamped ray parameters: any negative value reads as -1, anything at or
  // above 2^31 reads as 2^31, which is beyond every possible best distance.
  localparam logic signed [T_W-1:0] T_NEG = -T_W'(1);
  localparam logic signed [T_W-1:0] T_SAT = T_W'(1) <<< QBITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  typedef struct packed {
    logic                      alive;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } box_t;

  typedef struct packed {
    logic live;
    logic last;
    logic [IDX_W-1:0] slot;
  } tok_t;

  typedef struct packed {
    logic ovf_lo;
    logic ovf_hi;
    logic neg_lo;
    logic neg_hi;
    logic in_slab;
  } axis_flags_t;

  typedef struct packed {
    tok_t              tok;
    axis_flags_t [2:0] ax;
  } line_t;

  function automatic logic signed [T_W-1:0] to_t(logic ovf, logic neg,
                                                 logic [QBITS-1:0] q);
    logic signed [T_W-1:0] r;
    if (ovf) begin
      r = neg ? T_NEG : T_SAT;
    end else if (neg && (q != '0)) begin
      r = T_NEG;
    end else begin
      r = {2'b00, q};
    end
    return r;
  endfunction

endpackage

// File: sv/ray_box_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_nearest_hit
// Nearest live axis-aligned box hit by a ray, slab method in Q16.16.
// ----------------------------------------------------------------------------
// A load gives no result. During a query the box table, a ring of cells,
// rotates once past a six-lane division pipeline, one box per cycle; the
// pipeline holds 31 division cells plus four other stages.
// A query whose direction is all zero skips the scan and goes straight to
// done. busy is high until done; done carries the result for exactly one
// cycle and cannot be held.
module ray_box_nearest_hit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_we,
  input  logic [rbnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbnh_pkg::EXT_W-1:0]          cfg_data,
  input  logic                                req_type,
  input  logic [rbnh_pkg::SLOT_W-1:0]         slot,
  input  logic                                slot_alive,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_x,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_y,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_z,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_x,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_y,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_z,
  input  logic [rbnh_pkg::EXT_W-1:0]          max_dist,
  output logic                                hit,
  output logic [rbnh_pkg::SLOT_W-1:0]         hit_slot,
  output logic [rbnh_pkg::EXT_W-1:0]          hit_dist
);
  import rbnh_pkg::*;

  state_t state, state_next;

  logic accept, accept_load, accept_query, scanning;
  logic [EXT_W-1:0] half_width, half_height;
  logic [EXT_W-1:0] ext [3];

  logic signed [COORD_W-1:0] in_pt  [3];
  logic signed [COORD_W-1:0] in_dir [3];

  logic signed [COORD_W-1:0] org  [3];
  logic [DVS_W-1:0]          dvs  [3];
  logic [2:0]                dnz, dneg;

  logic [IDX_W-1:0] scan_cnt;
  logic             scan_last;

  logic [EXT_W-1:0] best;
  logic [IDX_W-1:0] best_slot;
  logic             found;

  box_t box_w [SLOTS];
  box_t load_box;
  logic signed [COORD_W-1:0] head_c [3];
  tok_t issue_tok;

  tok_t                     a_tok, b_tok, e_tok, f_tok;
  logic signed [DIFF_W-1:0] a_diff [3];
  logic signed [OFS_W-1:0]  b_xlo [3];
  logic signed [OFS_W-1:0]  b_xhi [3];
  logic [DVS_W-1:0]         c_rem  [6];
  logic [QBITS-1:0]         c_bits [6];
  logic [QBITS-1:0]         q_w    [6];
  line_t                    line [DIV_STAGES];
  line_t                    c_line;
  logic signed [T_W-1:0]    e_near [3];
  logic signed [T_W-1:0]    e_far  [3];
  axis_flags_t [2:0]        e_ax;
  logic signed [T_W-1:0]    f_tmin, tmin_v, tmax_v;
  logic                     f_ok, ok_v;

  assign in_pt[0]  = point_x;
  assign in_pt[1]  = point_y;
  assign in_pt[2]  = point_z;
  assign in_dir[0] = dir_x;
  assign in_dir[1] = dir_y;
  assign in_dir[2] = dir_z;
  assign ext[0]    = half_width;
  assign ext[1]    = half_height;
  assign ext[2]    = half_width;

  assign accept       = start && !busy;
  assign accept_load  = accept && (req_type == REQ_LOAD);
  assign accept_query = accept && (req_type == REQ_QUERY);
  assign scanning     = (state == ST_SCAN);
  assign scan_last    = (scan_cnt == IDX_W'(SLOTS - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= EXT_RESET;
      half_height <= EXT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_WIDTH:  half_width  <= cfg_data;
        CFG_HALF_HEIGHT: half_height <= cfg_data;
      endcase
    end
  end

  // Box table ring: cell 0 is the head that feeds the pipeline.
  assign load_box = '{alive: slot_alive, cx: point_x, cy: point_y, cz: point_z};

  for (genvar i = 0; i < SLOTS; i++) begin : g_box
    rbnh_box_cell u_box (
      .clk      (clk),
      .rst      (rst),
      .load_en  (accept_load && (int'(slot) == i)),
      .load_box (load_box),
      .shift_en (scanning),
      .shift_in (box_w[(i + 1) % SLOTS]),
      .box      (box_w[i])
    );
  end

  assign head_c[0] = box_w[0].cx;
  assign head_c[1] = box_w[0].cy;
  assign head_c[2] = box_w[0].cz;

  always_comb begin
    issue_tok = '0;
    if (scanning) begin
      issue_tok.live = box_w[0].alive;
      issue_tok.last = scan_last;
      issue_tok.slot = scan_cnt;
    end
  end

  // State machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_query) begin
          if ((dir_x == '0) && (dir_y == '0) && (dir_z == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (f_tok.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (accept_query) begin
      scan_cnt <= '0;
    end else if (scanning) begin
      scan_cnt <= scan_last ? '0 : IDX_W'(scan_cnt + 1'b1);
    end
  end

  // Query registers, constant for the whole scan.
  always_ff @(posedge clk) begin
    if (accept_query) begin
      for (int k = 0; k < 3; k++) begin
        org[k]  <= in_pt[k];
        dnz[k]  <= (in_dir[k] != '0);
        dneg[k] <= in_dir[k][COORD_W-1];
        dvs[k]  <= in_dir[k][COORD_W-1] ? DVS_W'(DVS_W'(0) - DVS_W'(in_dir[k]))
                                         : DVS_W'(in_dir[k]);
      end
    end
  end

  // Stage A: centre minus origin.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_diff[k] <= $signed({head_c[k][COORD_W-1], head_c[k]})
                 - $signed({org[k][COORD_W-1], org[k]});
    end
  end

  // Stage B: slab bounds relative to the origin.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      b_xlo[k] <= $signed({a_diff[k][DIFF_W-1], a_diff[k]})
                - $signed({3'b000, ext[k]});
      b_xhi[k] <= $signed({a_diff[k][DIFF_W-1], a_diff[k]})
                + $signed({3'b000, ext[k]});
    end
  end

  // Stage C: magnitudes, signs and the overflow test. The dividend is
  // |x| * 2^16; its top part above bit 30 seeds the remainder, and when that
  // part already reaches the divisor the quotient would not fit 31 bits.
  always_comb begin
    logic [OFS_W-1:0] mag;
    logic [DVS_W-1:0] top;
    c_line     = '0;
    c_line.tok = b_tok;
    for (int k = 0; k < 3; k++) begin
      for (int h = 0; h < 2; h++) begin
        mag = (h == 0) ? (b_xlo[k][OFS_W-1] ? OFS_W'(OFS_W'(0) - b_xlo[k]) : b_xlo[k])
                       : (b_xhi[k][OFS_W-1] ? OFS_W'(OFS_W'(0) - b_xhi[k]) : b_xhi[k]);
        top = DVS_W'(mag[OFS_W-1:QBITS-FRAC_W]);
        if (h == 0) begin
          c_line.ax[k].ovf_lo = (top >= dvs[k]);
          c_line.ax[k].neg_lo = b_xlo[k][OFS_W-1] ^ dneg[k];
        end else begin
          c_line.ax[k].ovf_hi = (top >= dvs[k]);
          c_line.ax[k].neg_hi = b_xhi[k][OFS_W-1] ^ dneg[k];
        end
        c_rem[2*k+h]  = top;
        c_bits[2*k+h] = {mag[QBITS-FRAC_W-1:0], FRAC_W'(0)};
      end
      c_line.ax[k].in_slab = (b_xlo[k] <= 0) && (b_xhi[k] >= 0);
    end
  end

  for (genvar l = 0; l < 6; l++) begin : g_lane
    rbnh_div_lane u_lane (
      .clk     (clk),
      .dvs     (dvs[l / 2]),
      .rem_in  (c_rem[l]),
      .bits_in (c_bits[l]),
      .q       (q_w[l])
    );
  end

  // Beat tags and flags travel alongside the division cells; the last entry
  // lines up with the quotient leaving the final cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok <= '0;
      b_tok <= '0;
      for (int j = 0; j < DIV_STAGES; j++) begin
        line[j] <= '0;
      end
      e_tok <= '0;
      f_tok <= '0;
    end else begin
      a_tok   <= issue_tok;
      b_tok   <= a_tok;
      line[0] <= c_line;
      for (int j = 1; j < DIV_STAGES; j++) begin
        line[j] <= line[j-1];
      end
      e_tok <= line[DIV_STAGES-1].tok;
      f_tok <= e_tok;
    end
  end

  // Stage E: signed, clamped entry and exit parameters per axis.
  always_ff @(posedge clk) begin
    e_ax <= line[DIV_STAGES-1].ax;
    for (int k = 0; k < 3; k++) begin
      if (dneg[k]) begin
        e_near[k] <= to_t(line[DIV_STAGES-1].ax[k].ovf_hi, line[DIV_STAGES-1].ax[k].neg_hi,
                          q_w[2*k+1]);
        e_far[k]  <= to_t(line[DIV_STAGES-1].ax[k].ovf_lo, line[DIV_STAGES-1].ax[k].neg_lo,
                          q_w[2*k]);
      end else begin
        e_near[k] <= to_t(line[DIV_STAGES-1].ax[k].ovf_lo, line[DIV_STAGES-1].ax[k].neg_lo,
                          q_w[2*k]);
        e_far[k]  <= to_t(line[DIV_STAGES-1].ax[k].ovf_hi, line[DIV_STAGES-1].ax[k].neg_hi,
                          q_w[2*k+1]);
      end
    end
  end

  // Stage F: combine the axes. An axis with zero direction only gates.
  always_comb begin
    tmin_v = '0;
    tmax_v = T_SAT;
    ok_v   = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (dnz[k]) begin
        if (e_near[k] > tmin_v) begin
          tmin_v = e_near[k];
        end
        if (e_far[k] < tmax_v) begin
          tmax_v = e_far[k];
        end
      end else if (!e_ax[k].in_slab) begin
        ok_v = 1'b0;
      end
    end
    ok_v = ok_v && (tmin_v <= tmax_v);
  end

  always_ff @(posedge clk) begin
    f_tmin <= tmin_v;
    f_ok   <= ok_v;
  end

  // Stage G: running nearest hit; a tie keeps the earlier slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept_query) begin
      found <= 1'b0;
    end else if (f_tok.live && f_ok && (f_tmin < $signed({2'b00, best}))) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query) begin
      best      <= max_dist;
      best_slot <= '0;
    end else if (f_tok.live && f_ok && (f_tmin < $signed({2'b00, best}))) begin
      best      <= f_tmin[EXT_W-1:0];
      best_slot <= f_tok.slot;
    end
  end

  assign hit      = found;
  assign hit_slot = found ? SLOT_W'(best_slot) : '0;
  assign hit_dist = found ? best : '0;

endmodule

// File: sv/rbnh_box_cell.sv
// ----------------------------------------------------------------------------
// rbnh_box_cell
// One box slot of the rotating table: loaded directly, or takes its neighbor.
// ----------------------------------------------------------------------------
module rbnh_box_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_en,
  input  rbnh_pkg::box_t load_box,
  input  logic          shift_en,
  input  rbnh_pkg::box_t shift_in,
  output rbnh_pkg::box_t box
);
  import rbnh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      box.alive <= 1'b0;
    end else if (load_en) begin
      box.alive <= load_box.alive;
    end else if (shift_en) begin
      box.alive <= shift_in.alive;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      box.cx <= load_box.cx;
      box.cy <= load_box.cy;
      box.cz <= load_box.cz;
    end else if (shift_en) begin
      box.cx <= shift_in.cx;
      box.cy <= shift_in.cy;
      box.cz <= shift_in.cz;
    end
  end

endmodule

// File: sv/rbnh_div_cell.sv
// ----------------------------------------------------------------------------
// rbnh_div_cell
// One restoring-division step: brings in one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module rbnh_div_cell (
  input  logic                       clk,
  input  logic [rbnh_pkg::DVS_W-1:0] dvs,
  input  logic [rbnh_pkg::DVS_W-1:0] rem_in,
  input  logic [rbnh_pkg::QBITS-1:0] bits_in,
  output logic [rbnh_pkg::DVS_W-1:0] rem,
  output logic [rbnh_pkg::QBITS-1:0] bits
);
  import rbnh_pkg::*;

  logic [DVS_W:0] trial;
  logic           qb;

  always_comb begin
    trial = {rem_in, bits_in[QBITS-1]};
    qb    = (trial >= {1'b0, dvs});
  end

  // While the seed is below the divisor the remainder stays below it, so it fits DVS_W bits.
  always_ff @(posedge clk) begin
    rem  <= qb ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    bits <= {bits_in[QBITS-2:0], qb};
  end

endmodule

// File: sv/rbnh_div_lane.sv
// ----------------------------------------------------------------------------
// rbnh_div_lane
// A chain of division cells; one quotient per cycle.
// ----------------------------------------------------------------------------
module rbnh_div_lane (
  input  logic                       clk,
  input  logic [rbnh_pkg::DVS_W-1:0] dvs,
  input  logic [rbnh_pkg::DVS_W-1:0] rem_in,
  input  logic [rbnh_pkg::QBITS-1:0] bits_in,
  output logic [rbnh_pkg::QBITS-1:0] q
);
  import rbnh_pkg::*;

  logic [DVS_W-1:0] rem_w  [DIV_STAGES+1];
  logic [QBITS-1:0] bits_w [DIV_STAGES+1];

  assign rem_w[0]  = rem_in;
  assign bits_w[0] = bits_in;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_cell
    rbnh_div_cell u_cell (
      .clk     (clk),
      .dvs     (dvs),
      .rem_in  (rem_w[j]),
      .bits_in (bits_w[j]),
      .rem     (rem_w[j+1]),
      .bits    (bits_w[j+1])
    );
  end

  assign q = bits_w[DIV_STAGES];

endmodule

// File: bench/rbnh_checker.sv
// ----------------------------------------------------------------------------
// rbnh_checker
// Watches the command, configuration and result ports of ray_box_nearest_hit,
// keeps its own box table and extents, predicts each query's nearest hit and
// compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module rbnh_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                done,
  input  logic                                cfg_we,
  input  logic [rbnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbnh_pkg::EXT_W-1:0]          cfg_data,
  input  logic                                req_type,
  input  logic [rbnh_pkg::SLOT_W-1:0]         slot,
  input  logic                                slot_alive,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_x,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_y,
  input  logic signed [rbnh_pkg::COORD_W-1:0] point_z,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_x,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_y,
  input  logic signed [rbnh_pkg::COORD_W-1:0] dir_z,
  input  logic [rbnh_pkg::EXT_W-1:0]          max_dist,
  input  logic                                hit,
  input  logic [rbnh_pkg::SLOT_W-1:0]         hit_slot,
  input  logic [rbnh_pkg::EXT_W-1:0]          hit_dist,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbnh_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [EXT_W-1:0]  hdist;
  } hit_rec_t;

  box_t             boxes [SLOTS];
  logic [EXT_W-1:0] ext_xz;
  logic [EXT_W-1:0] ext_y;
  hit_rec_t         hits_due [$];

  assign pending = hits_due.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Slab test over every live box in ascending slot order.
  function automatic hit_rec_t nearest_hit(input longint ox, oy, oz,
                                           input longint dx, dy, dz,
                                           input longint range);
    hit_rec_t r;
    longint org[3], dir[3], ext[3], c[3];
    longint best, tmin, tmax, lo, hi, t1, t2, tt;
    bit ok;
    r = '0;
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
    ext = '{longint'(ext_xz), longint'(ext_y), longint'(ext_xz)};
    best = range;
    if (dx == 0 && dy == 0 && dz == 0) return r;
    for (int i = 0; i < SLOTS; i++) begin
      if (!boxes[i].alive) continue;
      c = '{longint'(boxes[i].cx), longint'(boxes[i].cy), longint'(boxes[i].cz)};
      tmin = 0;
      tmax = best;
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
        lo = c[k] - ext[k];
        hi = c[k] + ext[k];
        if (dir[k] == 0) begin
          if (org[k] < lo || org[k] > hi) begin
            ok = 1'b0;
            break;
          end
          continue;
        end
        t1 = ((lo - org[k]) * 65536) / dir[k];
        t2 = ((hi - org[k]) * 65536) / dir[k];
        if (t1 > t2) begin
          tt = t1; t1 = t2; t2 = tt;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok && tmin < best) begin
        best = tmin;
        r.hit = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end
    if (r.hit) r.hdist = EXT_W'(best);
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    hit_rec_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) boxes[i] <= '0;
      ext_xz <= EXT_RESET;
      ext_y  <= EXT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_WIDTH) ext_xz <= cfg_data;
        else if (cfg_index == CFG_HALF_HEIGHT) ext_y <= cfg_data;
      end
      if (start && !busy) begin
        if (req_type == REQ_LOAD) begin
          if (slot < SLOTS) boxes[slot] <= '{slot_alive, point_x, point_y, point_z};
        end else begin
          hits_due.push_back(nearest_hit(point_x, point_y, point_z, dir_x, dir_y, dir_z,
                                         longint'(max_dist)));
        end
      end
      if (done) begin
        if (hits_due.size() == 0) begin
          report("result beat with no query outstanding");
        end else begin
          want = hits_due.pop_front();
          if (hit !== want.hit)
            report($sformatf("hit %b, expected %b", hit, want.hit));
          if (hit_slot !== want.slot)
            report($sformatf("hit_slot %0d, expected %0d", hit_slot, want.slot));
          if (hit_dist !== want.hdist)
            report($sformatf("hit_dist %0d, expected %0d", hit_dist, want.hdist));
        end
      end
    end
  end

endmodule

// File: bench/tb_ray_box_nearest_hit.sv
// ----------------------------------------------------------------------------
// tb_ray_box_nearest_hit
// Drives loads and ray queries into ray_box_nearest_hit over several extent
// settings: a directed opening, then queries aimed at loaded boxes mixed with
// random noise. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ray_box_nearest_hit;
  timeunit 1ns;
  timeprecision 1ps;
  import rbnh_pkg::*;

  localparam int ONE        = 65536;
  localparam int STALL_MAX  = 4000;
  localparam int ITEMS_PHASE = 130;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy, done;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_HALF_WIDTH;
  logic [EXT_W-1:0]          cfg_data = '0;
  logic                      req_type = REQ_LOAD;
  logic [SLOT_W-1:0]         slot = '0;
  logic                      slot_alive = 1'b0;
  logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [EXT_W-1:0]          max_dist = '0;
  logic                      hit;
  logic [SLOT_W-1:0]         hit_slot;
  logic [EXT_W-1:0]          hit_dist;
  int                        fail_count, pending;
  int                        quiet_cycles = 0;
  bit                        gaps_on = 1'b1;
  logic signed [COORD_W-1:0] centres [SLOTS][3];

  always #2 clk = ~clk;

  ray_box_nearest_hit u_top (.*);

  rbnh_checker u_chk (.*);

  // Watchdog: any beat on any port counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("ray_box_nearest_hit verification failed");
      $finish;
    end
  end

  task automatic send_beat();
    bit taken;
    if (gaps_on && $urandom_range(99) < 34) repeat ($urandom_range(1, 5)) @(negedge clk);
    start = 1'b1;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    start = 1'b0;
  endtask

  task automatic load_box(input int s, input bit alive, input int x, y, z);
    req_type = REQ_LOAD;
    slot = SLOT_W'(s);
    slot_alive = alive;
    point_x = x; point_y = y; point_z = z;
    centres[s] = '{x, y, z};
    send_beat();
  endtask

  task automatic cast_ray(input int x, y, z, input int dx, dy, dz,
                          input logic [EXT_W-1:0] range);
    req_type = REQ_QUERY;
    point_x = x; point_y = y; point_z = z;
    dir_x = dx; dir_y = dy; dir_z = dz;
    max_dist = range;
    send_beat();
  endtask

  // Only while idle: all results in and the block no longer busy.
  task automatic set_extents(input logic [EXT_W-1:0] xz, input logic [EXT_W-1:0] y);
    while (pending != 0 || busy) @(negedge clk);
    repeat (110) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_HALF_WIDTH;
    cfg_data = xz;
    @(negedge clk);
    cfg_index = CFG_HALF_HEIGHT;
    cfg_data = y;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int near_coord();
    return $signed($urandom_range(0, 128 * ONE)) - 64 * ONE;
  endfunction

  task automatic random_item();
    int s, r, ox, oy, oz;
    r = $urandom_range(99);
    s = $urandom_range(SLOTS - 1);
    if (r < 30) begin
      load_box(s, $urandom_range(99) < 85, near_coord(), near_coord(), near_coord());
    end else if (r < 80) begin
      // Ray aimed at a loaded centre, with jitter and the odd zero axis.
      ox = centres[s][0] + $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
      oy = centres[s][1] + $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
      oz = centres[s][2] + $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
      cast_ray(ox, oy, oz,
               ($urandom_range(9) == 0) ? 0 : centres[s][0] - ox + $signed($urandom_range(0, 8191)) - 4096,
               ($urandom_range(9) == 0) ? 0 : centres[s][1] - oy + $signed($urandom_range(0, 8191)) - 4096,
               ($urandom_range(9) == 0) ? 0 : centres[s][2] - oz + $signed($urandom_range(0, 8191)) - 4096,
               ($urandom_range(1) == 0) ? {EXT_W{1'b1}} :
               ($urandom_range(1) == 0) ? EXT_W'($urandom_range(0, 4 * ONE)) : EXT_W'($urandom));
    end else if (r < 90) begin
      load_box(s, $urandom_range(1), $urandom, $urandom, $urandom);
    end else begin
      cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, EXT_W'($urandom));
    end
  endtask

  initial begin
    logic [EXT_W-1:0] xz_set [5];
    logic [EXT_W-1:0] y_set [5];
    xz_set = '{EXT_RESET, '0, {EXT_W{1'b1}}, EXT_W'(3 * ONE), '0};
    y_set  = '{EXT_RESET, '0, {EXT_W{1'b1}}, EXT_W'(ONE / 4), {EXT_W{1'b1}}};
    for (int i = 0; i < SLOTS; i++) centres[i] = '{0, 0, 0};
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed opening at reset extents (half a unit).
    cast_ray(0, 0, 0, ONE, 0, 0, {EXT_W{1'b1}});            // empty table
    load_box(0, 1'b1, 2 * ONE, 0, 0);
    load_box(63, 1'b1, 2 * ONE, 0, 0);                       // same box, higher slot
    cast_ray(0, 0, 0, ONE, 0, 0, {EXT_W{1'b1}});            // tie keeps slot 0
    cast_ray(0, 0, 0, ONE, 0, 0, EXT_W'(98304));             // entry exactly at range
    cast_ray(0, 0, 0, ONE, 0, 0, EXT_W'(98305));
    cast_ray(0, 0, 0, 0, 0, 0, {EXT_W{1'b1}});               // zero direction
    cast_ray(0, ONE, 0, ONE, 0, 0, {EXT_W{1'b1}});           // zero axis, outside slab
    cast_ray(0, ONE / 2, 0, ONE, 0, 0, {EXT_W{1'b1}});       // zero axis, on the bound
    cast_ray(2 * ONE, 0, 0, 0, ONE, 0, {EXT_W{1'b1}});       // origin inside the box
    cast_ray(4 * ONE, 0, 0, -ONE, 0, 0, {EXT_W{1'b1}});
    cast_ray(0, 0, 0, -ONE, 0, 0, {EXT_W{1'b1}});            // box behind the ray
    load_box(0, 1'b0, 2 * ONE, 0, 0);                        // free slot 0
    cast_ray(0, 0, 0, ONE, 0, 0, {EXT_W{1'b1}});
    load_box(5, 1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    load_box(6, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    cast_ray(0, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, {EXT_W{1'b1}});
    cast_ray(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, {EXT_W{1'b1}});
    cast_ray(32'sh8000_0000, 0, 32'sh7fff_ffff, 1, -1, 1, '0);
    cast_ray(0, 0, 0, 1, 1, 1, {EXT_W{1'b1}});

    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_extents(xz_set[p], y_set[p]);
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        gaps_on = !(p == 2 && n >= 20 && n < 110);
        random_item();
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("ray_box_nearest_hit verification clean");
    end else begin
      $display("ray_box_nearest_hit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rbnh_pkg.sv
sv/rbnh_box_cell.sv
sv/rbnh_div_cell.sv
sv/rbnh_div_lane.sv
sv/ray_box_nearest_hit.sv
bench/rbnh_checker.sv
bench/tb_ray_box_nearest_hit.sv
